// ===== src/deq_pkg.sv =====
// Shared types, codes and constants for the double-ended queue.
`timescale 1ns / 1ps

package deq_pkg;

  // Default ring depth and fixed field widths
  localparam int DEPTH_DEFAULT = 16;
  localparam int DATA_W        = 32;
  localparam int OCC_W         = 5;

  typedef logic [1:0] kind_t;
  typedef logic [1:0] status_t;

  // Request kinds
  localparam kind_t KIND_PUSH_FRONT = 2'd0;
  localparam kind_t KIND_PUSH_BACK  = 2'd1;
  localparam kind_t KIND_POP_FRONT  = 2'd2;
  localparam kind_t KIND_POP_BACK   = 2'd3;

  // Result status codes
  localparam status_t ST_OK        = 2'd0;
  localparam status_t ST_UNDERFLOW = 2'd1;
  localparam status_t ST_OVERFLOW  = 2'd2;

  // Front and back value shown while the queue is empty
  localparam logic signed [DATA_W-1:0] EMPTY_MARK = -32'sd1;

  typedef struct packed {
    kind_t                     kind;
    logic signed [DATA_W-1:0]  value;
  } req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0]  popped_value;
    status_t                   status;
    logic signed [DATA_W-1:0]  front_value;
    logic signed [DATA_W-1:0]  back_value;
    logic [OCC_W-1:0]          occupancy;
  } rsp_t;

endpackage

// ===== src/double_ended_queue.sv =====
// Top level of the double-ended queue: control, ring storage and result register.
//
//   channel | valid     | stall     | payload | carries
//   request | req_valid | req_stall | req     | kind, value
//   result  | rsp_valid | rsp_stall | rsp     | popped value, status, ends, occupancy
//
// An item with no ring read (a push, a failed request, a pop that empties the queue)
// goes from S_IDLE straight to S_DONE; a pop that leaves the queue non-empty passes
// through S_READ first, for the ring read of the new front or back. From S_DONE the
// result moves to the output register once it is free, and the control returns to
// S_IDLE to accept the next request; a stalled result holds back at most one further
// item. Synchronous reset empties the queue, idles the control and clears rsp_valid.
`timescale 1ns / 1ps

module double_ended_queue #(
  parameter int DEPTH = deq_pkg::DEPTH_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  deq_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output deq_pkg::rsp_t rsp
);
  import deq_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic                     res_valid;
  logic                     res_take;
  rsp_t                     res;
  logic                     wr_en;
  logic [AW-1:0]            wr_addr;
  logic signed [DATA_W-1:0] wr_data;
  logic                     rd_en;
  logic [AW-1:0]            rd_addr;
  logic signed [DATA_W-1:0] rd_data;

  deq_ctrl #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .CW    (CW)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res       (res),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data)
  );

  deq_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Move a finished item into the output register when it is free
  assign res_take = res_valid && (!rsp_valid || !rsp_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_take) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  // Hold the item payload until it is taken
  always_ff @(posedge clk) begin
    if (res_take) begin
      rsp <= res;
    end
  end

endmodule

// ===== src/deq_ram.sv =====
// Ring storage: one write port, one read port with registered read data.
`timescale 1ns / 1ps

module deq_ram #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic                         clk,
  input  logic                         wr_en,
  input  logic [AW-1:0]                wr_addr,
  input  logic signed [deq_pkg::DATA_W-1:0] wr_data,
  input  logic                         rd_en,
  input  logic [AW-1:0]                rd_addr,
  output logic signed [deq_pkg::DATA_W-1:0] rd_data
);
  import deq_pkg::*;

  logic signed [DATA_W-1:0] mem [DEPTH];

  // Write one entry
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read one entry, data valid the next cycle
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== src/deq_ctrl.sv =====
// Queue control: pointers, count, cached end values and the per-item sequencer.
`timescale 1ns / 1ps

module deq_ctrl #(
  parameter int DEPTH = 16,
  parameter int AW    = 4,
  parameter int CW    = 5
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              req_valid,
  output logic                              req_stall,
  input  deq_pkg::req_t                     req,
  output logic                              res_valid,
  input  logic                              res_take,
  output deq_pkg::rsp_t                     res,
  output logic                              wr_en,
  output logic [AW-1:0]                     wr_addr,
  output logic signed [deq_pkg::DATA_W-1:0] wr_data,
  output logic                              rd_en,
  output logic [AW-1:0]                     rd_addr,
  input  logic signed [deq_pkg::DATA_W-1:0] rd_data
);
  import deq_pkg::*;

  localparam int SW = CW + 1;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_READ = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t                   state;
  logic [AW-1:0]            head;
  logic [CW-1:0]            count;
  logic signed [DATA_W-1:0] front_val;
  logic signed [DATA_W-1:0] back_val;
  logic signed [DATA_W-1:0] popped;
  status_t                  status_q;
  logic                     rd_front;

  logic                     accept;
  logic                     empty;
  logic                     full;
  logic [CW-1:0]            offset;
  logic [SW-1:0]            pos_sum;
  logic [AW-1:0]            pos_addr;
  logic [AW-1:0]            head_dec;
  logic [AW-1:0]            head_inc;
  status_t                  op_status;

  // Decode the request and form ring addresses
  always_comb begin
    accept  = req_valid && (state == S_IDLE);
    empty   = (count == '0);
    full    = (count == CW'(DEPTH));
    // Back end of the ring for a push, new last entry for a pop
    offset  = (req.kind == KIND_PUSH_BACK) ? count : count - CW'(2);
    pos_sum = SW'(head) + SW'(offset);
    if (pos_sum >= SW'(DEPTH)) begin
      pos_sum = pos_sum - SW'(DEPTH);
    end
    pos_addr = pos_sum[AW-1:0];
    head_dec = (head == '0) ? AW'(DEPTH - 1) : head - AW'(1);
    head_inc = (head == AW'(DEPTH - 1)) ? '0 : head + AW'(1);

    wr_en     = 1'b0;
    wr_addr   = pos_addr;
    wr_data   = req.value;
    rd_en     = 1'b0;
    rd_addr   = head_inc;
    op_status = ST_OK;
    unique case (req.kind)
      KIND_PUSH_FRONT: begin
        wr_addr = head_dec;
        if (full) op_status = ST_OVERFLOW;
        else      wr_en     = accept;
      end
      KIND_PUSH_BACK: begin
        if (full) op_status = ST_OVERFLOW;
        else      wr_en     = accept;
      end
      KIND_POP_FRONT: begin
        rd_addr = head_inc;
        if (empty) op_status = ST_UNDERFLOW;
        else       rd_en     = accept && (count > CW'(1));
      end
      KIND_POP_BACK: begin
        rd_addr = pos_addr;
        if (empty) op_status = ST_UNDERFLOW;
        else       rd_en     = accept && (count > CW'(1));
      end
    endcase
  end

  // Sequence one item: update state, refresh an end value, hand off the result
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      head  <= '0;
      count <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            status_q <= op_status;
            popped   <= '0;
            rd_front <= (req.kind == KIND_POP_FRONT);
            if (op_status == ST_OK) begin
              unique case (req.kind)
                KIND_PUSH_FRONT: begin
                  head      <= head_dec;
                  count     <= count + CW'(1);
                  front_val <= req.value;
                  if (empty) back_val <= req.value;
                end
                KIND_PUSH_BACK: begin
                  count    <= count + CW'(1);
                  back_val <= req.value;
                  if (empty) front_val <= req.value;
                end
                KIND_POP_FRONT: begin
                  popped <= front_val;
                  head   <= head_inc;
                  count  <= count - CW'(1);
                end
                KIND_POP_BACK: begin
                  popped <= back_val;
                  count  <= count - CW'(1);
                end
              endcase
            end
            state <= rd_en ? S_READ : S_DONE;
          end
        end
        S_READ: begin
          // Load the new end value after a pop
          if (rd_front) front_val <= rd_data;
          else          back_val  <= rd_data;
          state <= S_DONE;
        end
        S_DONE: begin
          if (res_take) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Present the result from the state left by the item
  always_comb begin
    req_stall          = (state != S_IDLE);
    res_valid          = (state == S_DONE);
    res.popped_value   = popped;
    res.status         = status_q;
    res.front_value    = empty ? EMPTY_MARK : front_val;
    res.back_value     = empty ? EMPTY_MARK : back_val;
    res.occupancy      = OCC_W'(count);
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("element count above ring depth");

  a_head_bound: assert property (@(posedge clk) disable iff (rst)
    head <= AW'(DEPTH - 1))
    else $error("head index outside ring");

  a_read_follows: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ) |-> $past(rd_en))
    else $error("read state without a ring read");

  a_no_rw_overlap: assert property (@(posedge clk) disable iff (rst)
    !(wr_en && rd_en))
    else $error("ring read and write in the same cycle");

  a_overflow_hold: assert property (@(posedge clk) disable iff (rst)
    (accept && (op_status == ST_OVERFLOW)) |=> (count == $past(count)) && $stable(head))
    else $error("dropped push changed the queue");

endmodule

// ===== bench/deq_monitor.sv =====
// Request/result monitor for the double-ended queue: predicts each result and compares it.
`timescale 1ns / 1ps

module deq_monitor (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  input  logic          req_stall,
  input  deq_pkg::req_t req,
  input  logic          rsp_valid,
  input  logic          rsp_stall,
  input  deq_pkg::rsp_t rsp,
  output int            fail_count,
  output int            pending
);
  import deq_pkg::*;

  localparam int DEPTH = DEPTH_DEFAULT;

  // Shadow of the ring contents, front position and element count
  logic signed [DATA_W-1:0] shadow_ring [DEPTH];
  int                       shadow_head;
  int                       shadow_count;

  rsp_t owed_results [$];
  int   mismatch_total = 0;

  assign fail_count = mismatch_total;

  // Apply one request to the shadow deque and return the result it should produce
  function automatic rsp_t apply_request(req_t r);
    rsp_t o;
    o = '0;
    o.status = ST_OK;
    if (r.kind == KIND_PUSH_FRONT || r.kind == KIND_PUSH_BACK) begin
      if (shadow_count >= DEPTH) begin
        o.status = ST_OVERFLOW;
      end else if (r.kind == KIND_PUSH_FRONT) begin
        shadow_head = (shadow_head + DEPTH - 1) % DEPTH;
        shadow_ring[shadow_head] = r.value;
        shadow_count++;
      end else begin
        shadow_ring[(shadow_head + shadow_count) % DEPTH] = r.value;
        shadow_count++;
      end
    end else begin
      if (shadow_count == 0) begin
        o.status = ST_UNDERFLOW;
      end else if (r.kind == KIND_POP_FRONT) begin
        o.popped_value = shadow_ring[shadow_head];
        shadow_head = (shadow_head + 1) % DEPTH;
        shadow_count--;
      end else begin
        o.popped_value = shadow_ring[(shadow_head + shadow_count - 1) % DEPTH];
        shadow_count--;
      end
    end
    // Both ends read as the empty mark once nothing is stored
    if (shadow_count == 0) begin
      o.front_value = EMPTY_MARK;
      o.back_value  = EMPTY_MARK;
    end else begin
      o.front_value = shadow_ring[shadow_head];
      o.back_value  = shadow_ring[(shadow_head + shadow_count - 1) % DEPTH];
    end
    o.occupancy = shadow_count[OCC_W-1:0];
    return o;
  endfunction

  function automatic void check_field(string name, logic [DATA_W-1:0] want,
                                      logic [DATA_W-1:0] got);
    if (want !== got) begin
      mismatch_total++;
      if (mismatch_total <= 10)
        $display("%0t ns: %s mismatch: expected %h, got %h", $realtime, name, want, got);
    end
  endfunction

  // Record accepted items, then match each accepted result against the oldest one owed
  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      shadow_head  = 0;
      shadow_count = 0;
      owed_results.delete();
    end else begin
      if (req_valid && !req_stall)
        owed_results.insert(owed_results.size(), apply_request(req));
      if (rsp_valid && !rsp_stall) begin
        if (owed_results.size() == 0) begin
          mismatch_total++;
          if (mismatch_total <= 10)
            $display("%0t ns: result with no item outstanding: %h", $realtime, rsp);
        end else begin
          want = owed_results[0];
          owed_results.delete(0);
          check_field("popped_value", want.popped_value, rsp.popped_value);
          check_field("status", DATA_W'(want.status), DATA_W'(rsp.status));
          check_field("front_value", want.front_value, rsp.front_value);
          check_field("back_value", want.back_value, rsp.back_value);
          check_field("occupancy", DATA_W'(want.occupancy), DATA_W'(rsp.occupancy));
        end
      end
    end
    pending <= owed_results.size();
  end

endmodule

// ===== bench/tb.sv =====
// Testbench top for the double-ended queue: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb;
  import deq_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;
  int   fail_count;
  int   pending;

  int stall_mode = 0;
  int stall_left = 0;

  double_ended_queue uut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  deq_monitor mon (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .req        (req),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .rsp        (rsp),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Stall results in modes that change now and then: none, light, heavy, solid
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(20, 80);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: rsp_stall <= 1'b0;
      1: rsp_stall <= ($urandom_range(0, 99) < 30);
      2: rsp_stall <= ($urandom_range(0, 99) < 70);
      default: rsp_stall <= 1'b1;
    endcase
  end

  // Offer one item and hold it until it is taken
  task automatic send_item(kind_t k, logic signed [DATA_W-1:0] v);
    req.kind  <= k;
    req.value <= v;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall);
  endtask

  task automatic hold_off(int cycles);
    req_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Drop valid and wait until every owed result has come back
  task automatic wait_for_drain();
    req_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    #1_000_000;
    $display("tb: FAIL");
    $finish;
  end

  initial begin
    int burst_left;
    int push_pct;
    kind_t k;
    logic signed [DATA_W-1:0] v;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Pops on an empty queue underflow
    send_item(KIND_POP_FRONT, 32'sh1234_5678);
    send_item(KIND_POP_BACK, -32'sd1);
    // Extremes in, then out from both ends down to empty
    send_item(KIND_PUSH_FRONT, 32'sh7fff_ffff);
    send_item(KIND_PUSH_BACK, 32'sh8000_0000);
    send_item(KIND_POP_FRONT, 32'sd0);
    send_item(KIND_POP_BACK, 32'sd0);
    // Fill to capacity from both ends, wrapping the ring
    for (int i = 0; i < DEPTH_DEFAULT; i++) begin
      if (i == 0) v = 32'sd0;
      else if (i == 1) v = -32'sd1;
      else if (i == 2) v = 32'sh7fff_ffff;
      else if (i == 3) v = 32'sh8000_0000;
      else v = $urandom;
      send_item((i % 2 == 0) ? KIND_PUSH_FRONT : KIND_PUSH_BACK, v);
    end
    // Pushes on a full queue are dropped
    send_item(KIND_PUSH_FRONT, 32'sh0bad_0001);
    send_item(KIND_PUSH_BACK, 32'sh0bad_0002);
    send_item(KIND_POP_FRONT, 32'sd0);
    send_item(KIND_POP_BACK, 32'sd0);

    // Random traffic in bursts, drifting between filling and draining
    burst_left = 0;
    for (int n = 0; n < 550; n++) begin
      if (n % 137 == 136)
        wait_for_drain();
      if (burst_left == 0) begin
        if ($urandom_range(0, 3) != 0)
          hold_off($urandom_range(1, 8));
        burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      case ((n / 40) % 4)
        0: push_pct = 85;
        2: push_pct = 15;
        default: push_pct = 50;
      endcase
      if ($urandom_range(0, 99) < push_pct)
        k = ($urandom_range(0, 1) != 0) ? KIND_PUSH_BACK : KIND_PUSH_FRONT;
      else
        k = ($urandom_range(0, 1) != 0) ? KIND_POP_BACK : KIND_POP_FRONT;
      case ($urandom_range(0, 7))
        0: v = 32'sh7fff_ffff;
        1: v = 32'sh8000_0000;
        2: v = -32'sd1;
        3: v = $urandom_range(0, 15);
        default: v = $urandom;
      endcase
      send_item(k, v);
    end

    wait_for_drain();
    repeat (10) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("tb: PASS");
    else
      $display("tb: FAIL");
    $finish;
  end

endmodule

// ===== double_ended_queue.f =====
src/deq_pkg.sv
src/deq_ram.sv
src/deq_ctrl.sv
src/double_ended_queue.sv
bench/deq_monitor.sv
bench/tb.sv
